// File: rtl/gmf_pkg.sv
// Shared types and constants of the grid local maximum finder.
package gmf_pkg;

  localparam int VALUE_W   = 32;
  localparam int PEAK_W    = 10;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 2'd1;

  localparam int MAX_REPORTS = 3;
  localparam int FIFO_DEPTH  = 8;
  localparam int FIFO_AW     = 3;
  localparam int FIFO_CW     = 4;
  localparam int STALL_LIMIT = FIFO_DEPTH - MAX_REPORTS;

  typedef struct packed {
    logic signed [VALUE_W-1:0] rec;
    logic signed [VALUE_W-1:0] old;
  } line_t;

  typedef struct packed {
    logic [PEAK_W-1:0] row;
    logic [PEAK_W-1:0] col;
    logic              last;
    logic              done;
  } report_t;

endpackage

// File: rtl/grid_local_maximum_finder.sv
// Top level of the grid local maximum finder: line memory, decision stage and report queue.
// Flow: a request is registered into the decision stage, which writes its reports into the report queue.
// Throughput: one request per cycle while in_stall is low; set by the single line memory read per request.
// A last-row request can give two reports (the final cell three); the one-per-cycle output paces it.
// Reset: synchronous, active low; clears positions, the queue and the pipeline, sizes go to 1024.
// The line memory is not cleared; entries are always written before a grid uses them.
module grid_local_maximum_finder #(
  parameter int MAX_ROWS = 1024,
  parameter int MAX_COLS = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [gmf_pkg::VALUE_W-1:0] in_cell_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [gmf_pkg::PEAK_W-1:0]         out_peak_row,
  output logic [gmf_pkg::PEAK_W-1:0]         out_peak_col,
  output logic                               out_last_of_item,
  output logic                               out_grid_done,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gmf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gmf_pkg::CFG_W-1:0]          cfg_wdata
);
  import gmf_pkg::*;

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLS);
  localparam int ROWS_RST = (1024 > MAX_ROWS) ? MAX_ROWS - 1 : 1023;
  localparam int COLS_RST = (1024 > MAX_COLS) ? MAX_COLS - 1 : 1023;

  line_t line_mem [MAX_COLS];
  report_t fifo_mem [FIFO_DEPTH];

  logic [RW-1:0] rows_last_r, rows_last_nxt;
  logic [CW-1:0] cols_last_r, cols_last_nxt;
  logic [RW-1:0] row_pos_r, row_pos_nxt;
  logic [CW-1:0] col_pos_r, col_pos_nxt;

  logic          in_acc, cfg_acc, pop;
  logic          s0_last_row, s0_last_col;
  logic [CW-1:0] rd_addr;
  logic [31:0]   cfg_v32, cfg_lim, cfg_last32;

  logic                s1_valid_r;
  logic signed [VALUE_W-1:0] s1_value_r;
  logic [RW-1:0]       s1_row_r;
  logic [CW-1:0]       s1_col_r;
  logic [CW-1:0]       s1_raddr_r;
  logic                s1_last_row_r, s1_last_col_r;

  line_t rd_data_r, fwd_data_r, hold_r, rd_eff, wr_data, hold_nxt;
  logic  fwd_hit_r;
  logic signed [VALUE_W-1:0] left_r, cur1_r, cur2_r;
  logic signed [VALUE_W-1:0] up_v, old_v, right_v;

  logic r_ge1, r_ge2, c_ge1, c_ge2, s1_final;
  logic p_up, p_left, p_fin;
  report_t res_up, res_left, res_fin;
  logic [1:0] push_n;

  logic [FIFO_AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [FIFO_CW-1:0] cnt_r, cnt_nxt;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_stall  = (cnt_r + (s1_valid_r ? FIFO_CW'(MAX_REPORTS) : FIFO_CW'(0)))
                     > FIFO_CW'(STALL_LIMIT);
  assign in_acc    = in_valid && !in_stall;

  always_comb begin
    cfg_v32 = 32'(cfg_wdata);
    cfg_lim = (cfg_index == REG_NUM_ROWS) ? 32'(MAX_ROWS) : 32'(MAX_COLS);
    if (cfg_v32 == 32'd0) begin
      cfg_last32 = 32'd0;
    end else if (cfg_v32 > cfg_lim) begin
      cfg_last32 = cfg_lim - 32'd1;
    end else begin
      cfg_last32 = cfg_v32 - 32'd1;
    end
  end

  always_comb begin
    s0_last_row = (row_pos_r == rows_last_r);
    s0_last_col = (col_pos_r == cols_last_r);
    rd_addr     = s0_last_col ? CW'(0) : col_pos_r + CW'(1);

    rows_last_nxt = rows_last_r;
    cols_last_nxt = cols_last_r;
    row_pos_nxt   = row_pos_r;
    col_pos_nxt   = col_pos_r;
    if (cfg_acc && (cfg_index == REG_NUM_ROWS || cfg_index == REG_NUM_COLS)) begin
      if (cfg_index == REG_NUM_ROWS) begin
        rows_last_nxt = RW'(cfg_last32);
      end else begin
        cols_last_nxt = CW'(cfg_last32);
      end
      row_pos_nxt = '0;
      col_pos_nxt = '0;
    end else if (in_acc) begin
      if (s0_last_col) begin
        col_pos_nxt = '0;
        row_pos_nxt = s0_last_row ? RW'(0) : row_pos_r + RW'(1);
      end else begin
        col_pos_nxt = col_pos_r + CW'(1);
      end
    end
  end

  always_comb begin
    rd_eff   = fwd_hit_r ? fwd_data_r : rd_data_r;
    up_v     = hold_r.rec;
    old_v    = hold_r.old;
    right_v  = rd_eff.rec;
    wr_data  = '{rec: s1_value_r, old: hold_r.rec};
    hold_nxt = (s1_raddr_r == s1_col_r) ? wr_data : rd_eff;

    r_ge1    = (s1_row_r != RW'(0));
    r_ge2    = (s1_row_r > RW'(1));
    c_ge1    = (s1_col_r != CW'(0));
    c_ge2    = (s1_col_r > CW'(1));
    s1_final = s1_last_row_r && s1_last_col_r;

    p_up   = r_ge1 && (up_v >= s1_value_r) && (!r_ge2 || up_v >= old_v)
             && (!c_ge1 || up_v >= left_r) && (s1_last_col_r || up_v >= right_v);
    p_left = s1_last_row_r && c_ge1 && (!r_ge1 || cur1_r >= left_r)
             && (!c_ge2 || cur1_r >= cur2_r) && (cur1_r >= s1_value_r);
    p_fin  = s1_final && (!r_ge1 || s1_value_r >= up_v) && (!c_ge1 || s1_value_r >= cur1_r);

    res_up   = '{row: PEAK_W'(s1_row_r - RW'(1)), col: PEAK_W'(s1_col_r),
                 last: !p_left && !p_fin, done: s1_final};
    res_left = '{row: PEAK_W'(s1_row_r), col: PEAK_W'(s1_col_r - CW'(1)),
                 last: !p_fin, done: s1_final};
    res_fin  = '{row: PEAK_W'(s1_row_r), col: PEAK_W'(s1_col_r),
                 last: 1'b1, done: s1_final};

    push_n = s1_valid_r ? (2'(p_up) + 2'(p_left) + 2'(p_fin)) : 2'd0;
    pop    = out_valid && !out_stall;
    wp_nxt  = wp_r + FIFO_AW'(push_n);
    rp_nxt  = rp_r + FIFO_AW'(pop);
    cnt_nxt = cnt_r + FIFO_CW'(push_n) - FIFO_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_last_r <= RW'(ROWS_RST);
      cols_last_r <= CW'(COLS_RST);
      row_pos_r   <= '0;
      col_pos_r   <= '0;
      s1_valid_r  <= 1'b0;
      wp_r        <= '0;
      rp_r        <= '0;
      cnt_r       <= '0;
    end else begin
      rows_last_r <= rows_last_nxt;
      cols_last_r <= cols_last_nxt;
      row_pos_r   <= row_pos_nxt;
      col_pos_r   <= col_pos_nxt;
      s1_valid_r  <= in_acc;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      line_mem[s1_col_r] <= wr_data;
    end
    if (in_acc) begin
      rd_data_r <= line_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_value_r    <= in_cell_value;
      s1_row_r      <= row_pos_r;
      s1_col_r      <= col_pos_r;
      s1_raddr_r    <= rd_addr;
      s1_last_row_r <= s0_last_row;
      s1_last_col_r <= s0_last_col;
      fwd_hit_r     <= s1_valid_r && (s1_col_r == rd_addr);
      fwd_data_r    <= wr_data;
    end
    if (s1_valid_r) begin
      hold_r <= hold_nxt;
      left_r <= hold_r.rec;
      cur2_r <= cur1_r;
      cur1_r <= s1_value_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      if (p_up) begin
        fifo_mem[wp_r] <= res_up;
      end
      if (p_left) begin
        fifo_mem[wp_r + FIFO_AW'(p_up)] <= res_left;
      end
      if (p_fin) begin
        fifo_mem[wp_r + FIFO_AW'(2'(p_up) + 2'(p_left))] <= res_fin;
      end
    end
  end

  assign out_valid        = (cnt_r != FIFO_CW'(0));
  assign out_peak_row     = fifo_mem[rp_r].row;
  assign out_peak_col     = fifo_mem[rp_r].col;
  assign out_last_of_item = fifo_mem[rp_r].last;
  assign out_grid_done    = fifo_mem[rp_r].done;

endmodule

// File: rtl/gmf_checker.sv
// Port-level checker of the grid local maximum finder and its bind statement.
module gmf_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [gmf_pkg::PEAK_W-1:0]         out_peak_row,
  input logic [gmf_pkg::PEAK_W-1:0]         out_peak_col,
  input logic                               out_last_of_item,
  input logic                               out_grid_done
);
  import gmf_pkg::*;

  // A stalled report keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_peak_row) && $stable(out_peak_col)
      && $stable(out_last_of_item) && $stable(out_grid_done))
    else $error("stalled report changed");

  // The reports of one request are queued together, so a non-final one is always followed.
  a_item_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_item |=> out_valid)
    else $error("reports of one request were split");

  // Reports of one request agree on whether the grid is finished.
  a_done_same: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_item |=> out_grid_done == $past(out_grid_done))
    else $error("grid completion flag changed within a request");

  // Reset leaves the queue empty and the input open.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not empty after reset");

endmodule

bind grid_local_maximum_finder gmf_checker u_gmf_checker (.*);

// File: dv/tb_top.sv
// Self-checking testbench for the grid local maximum finder, with its own peak predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gmf_pkg::*;

  localparam int ROWS_CAP = 1024;
  localparam int COLS_CAP = 1024;
  localparam int RANDOM_CELLS = 250;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef logic signed [VALUE_W-1:0] cell_t;
  typedef enum {FLAT, NARROW, WIDE, EDGES} value_style_t;

  class peak_tracker;
    cell_t older_line[COLS_CAP];
    cell_t recent_line[COLS_CAP];
    cell_t current_line[COLS_CAP];
    logic [CFG_W-1:0] rows_reg = 11'd1024;
    logic [CFG_W-1:0] cols_reg = 11'd1024;
    int row_at;
    int col_at;
    report_t pending_peaks[$];
    int cells;
    int peaks;
    int grids;
    int mismatches;

    function int clamp(logic [CFG_W-1:0] v, int cap);
      if (v == 0) return 1;
      if (v > cap) return cap;
      return int'(v);
    endfunction

    function bit dominates(cell_t centre, bit has_above, cell_t above, bit has_below,
                           cell_t below, bit has_west, cell_t west, bit has_east, cell_t east);
      if (has_above && centre < above) return 0;
      if (has_below && centre < below) return 0;
      if (has_west && centre < west) return 0;
      if (has_east && centre < east) return 0;
      return 1;
    endfunction

    function report_t make_peak(int r, int c);
      report_t p;
      p.row = PEAK_W'(r);
      p.col = PEAK_W'(c);
      p.last = 1'b0;
      p.done = 1'b0;
      return p;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_NUM_ROWS: rows_reg = data;
        REG_NUM_COLS: cols_reg = data;
        default: return;
      endcase
      row_at = 0;
      col_at = 0;
    endfunction

    function void take_cell(cell_t v);
      int rows;
      int cols;
      int r;
      int c;
      bit last_row;
      bit final_cell;
      report_t found[$];
      rows = clamp(rows_reg, ROWS_CAP);
      cols = clamp(cols_reg, COLS_CAP);
      r = (row_at >= rows) ? 0 : row_at;
      c = (col_at >= cols) ? 0 : col_at;
      last_row = (r == rows - 1);
      final_cell = last_row && (c == cols - 1);
      current_line[c] = v;
      if (r >= 1 && dominates(recent_line[c], r >= 2, older_line[c], 1'b1, v,
                              c >= 1, recent_line[c >= 1 ? c - 1 : 0],
                              c + 1 < cols, recent_line[c + 1 < cols ? c + 1 : 0]))
        found.push_back(make_peak(r - 1, c));
      if (last_row && c >= 1 && dominates(current_line[c - 1], r >= 1, recent_line[c - 1],
                                          1'b0, '0, c >= 2, current_line[c >= 2 ? c - 2 : 0],
                                          1'b1, v))
        found.push_back(make_peak(r, c - 1));
      if (final_cell && dominates(v, r >= 1, recent_line[c], 1'b0, '0,
                                  c >= 1, current_line[c >= 1 ? c - 1 : 0], 1'b0, '0))
        found.push_back(make_peak(r, c));
      if (found.size() > 0) found[found.size() - 1].last = 1'b1;
      foreach (found[k]) begin
        found[k].done = final_cell;
        pending_peaks.push_back(found[k]);
      end
      cells++;
      if (final_cell) grids++;
      c++;
      if (c >= cols) begin
        c = 0;
        older_line = recent_line;
        recent_line = current_line;
        r++;
        if (final_cell || r >= rows) r = 0;
      end
      row_at = r;
      col_at = c;
    endfunction

    function void check_peak(report_t got);
      report_t want;
      peaks++;
      if (pending_peaks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("report with no request behind it: row %0d col %0d last %0b grid_done %0b",
                   got.row, got.col, got.last, got.done);
        return;
      end
      want = pending_peaks.pop_front();
      if (got.row !== want.row || got.col !== want.col || got.last !== want.last ||
          got.done !== want.done) begin
        mismatches++;
        if (mismatches <= 10)
          $display("report mismatch: row %0d/%0d col %0d/%0d last %0b/%0b grid_done %0b/%0b %s",
                   want.row, got.row, want.col, got.col, want.last, got.last,
                   want.done, got.done, "(expected/actual)");
      end
    endfunction

    function int outstanding();
      return pending_peaks.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  cell_t in_cell_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [PEAK_W-1:0] out_peak_row;
  logic [PEAK_W-1:0] out_peak_col;
  logic out_last_of_item;
  logic out_grid_done;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  peak_tracker tracker = new();
  int cycle_count;
  int choke_cycles;
  int hold_left;
  int window_left;
  int stall_pick;
  bit free_window;
  bit steady;
  int random_cells;

  grid_local_maximum_finder DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_cell_value(in_cell_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_peak_row(out_peak_row),
    .out_peak_col(out_peak_col),
    .out_last_of_item(out_last_of_item),
    .out_grid_done(out_grid_done),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else if (rst_n && out_valid && !out_stall) begin
      tracker.check_peak(report_t'({out_peak_row, out_peak_col, out_last_of_item,
                                    out_grid_done}));
    end
  end

  always @(negedge clk) begin
    if (choke_cycles > 0) begin
      choke_cycles--;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (window_left == 0) begin
        window_left = $urandom_range(80, 20);
        free_window = ($urandom_range(3) == 0);
      end
      window_left--;
      stall_pick = $urandom_range(99);
      if (free_window || stall_pick < 60) begin
        out_stall <= 1'b0;
      end else begin
        hold_left = (stall_pick < 92) ? $urandom_range(2) : $urandom_range(30, 10);
        out_stall <= 1'b1;
      end
    end
  end

  function int gap_len();
    int pick;
    if (steady) return 0;
    pick = $urandom_range(99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function cell_t draw_value(value_style_t style);
    case (style)
      FLAT: return '0;
      NARROW: return cell_t'(int'($urandom_range(4)) - 2);
      WIDE: return cell_t'($urandom);
      default: begin
        case ($urandom_range(4))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'hffff_ffff;
          3: return 32'h0000_0001;
          default: return '0;
        endcase
      end
    endcase
  endfunction

  function int pick_size();
    int pick;
    pick = $urandom_range(19);
    if (pick < 14) return $urandom_range(6, 1);
    return $urandom_range(24, 7);
  endfunction

  task automatic push_cell(cell_t v);
    @(negedge clk);
    in_valid = 1'b1;
    in_cell_value = v;
    do @(posedge clk); while (in_stall);
    tracker.take_cell(v);
  endtask

  task automatic pause(int n);
    if (n > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      in_cell_value = cell_t'($urandom);
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic settle();
    pause(1);
    while (tracker.outstanding() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    settle();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_wdata = data;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_index = CFG_IDX_W'($urandom);
    cfg_wdata = CFG_W'($urandom);
  endtask

  task automatic set_size(int rows, int cols);
    set_reg(REG_NUM_ROWS, CFG_W'(rows));
    set_reg(REG_NUM_COLS, CFG_W'(cols));
  endtask

  task automatic feed_cells(int count, value_style_t style);
    for (int i = 0; i < count; i++) begin
      push_cell(draw_value(style));
      pause(gap_len());
    end
  endtask

  task automatic push_values(cell_t vals[$]);
    foreach (vals[i]) begin
      push_cell(vals[i]);
      pause(gap_len());
    end
  endtask

  initial begin
    int rows;
    int cols;
    int grid_count;
    int n;
    int split;
    int pick;
    value_style_t style;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset sizes are 1024 by 1024, so the start of the first row gives no reports.
    feed_cells(40, NARROW);

    set_size(1, 1);
    push_values('{32'h8000_0000, 32'h7fff_ffff});
    set_size(1, 3);
    push_values('{32'sd7, 32'sd7, 32'sd7});
    set_size(3, 1);
    push_values('{32'sd0, 32'hffff_ffff, 32'h8000_0000});
    set_size(2, 2);
    push_values('{32'sd1, 32'sd2, 32'sd3, 32'sd0});
    push_values('{32'h7fff_ffff, -32'sd5, -32'sd5, 32'h7fff_ffff});
    set_size(2, 3);
    push_values('{32'sd4, -32'sd4});
    set_reg(REG_SPARE_A, 11'h7ff);
    push_values('{32'sd9});
    set_reg(REG_NUM_COLS, 11'd3);
    push_values('{32'sd1, 32'sd1, 32'sd0, 32'sd2, 32'sd1, 32'sd2});

    // Out-of-range sizes clamp: zero counts as one, anything above the cap as the cap.
    set_size(0, 2047);
    feed_cells(80, WIDE);
    set_size(2047, 0);
    feed_cells(80, EDGES);

    // The receiver holds off while a flat grid makes every cell a peak.
    set_size(4, 16);
    steady = 1'b1;
    choke_cycles = 200;
    feed_cells(64, FLAT);
    steady = 1'b0;

    while (random_cells < RANDOM_CELLS) begin
      rows = pick_size();
      cols = pick_size();
      if ($urandom_range(1)) begin
        set_reg(REG_NUM_COLS, CFG_W'(cols));
        set_reg(REG_NUM_ROWS, CFG_W'(rows));
      end else begin
        set_size(rows, cols);
      end
      steady = ($urandom_range(3) == 0);
      pick = $urandom_range(9);
      style = (pick < 5) ? NARROW : (pick < 7) ? WIDE : (pick < 9) ? EDGES : FLAT;
      grid_count = $urandom_range(3, 1);
      for (int g = 0; g < grid_count; g++) begin
        n = rows * cols;
        if (g == grid_count - 1 && $urandom_range(6) == 0) n = $urandom_range(n - 1, 0);
        if (n > RANDOM_CELLS - random_cells) n = RANDOM_CELLS - random_cells;
        if (g == 0 && $urandom_range(4) == 0) begin
          split = $urandom_range(n, 0);
          feed_cells(split, style);
          set_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, CFG_W'($urandom));
          feed_cells(n - split, style);
        end else begin
          feed_cells(n, style);
        end
        random_cells += n;
      end
      if ($urandom_range(7) == 0) settle();
    end
    steady = 1'b0;

    pause(1);
    while (tracker.outstanding() > 0) @(posedge clk);
    repeat (2 * DRAIN_CYCLES) @(posedge clk);
    if (tracker.outstanding() > 0) begin
      $display("%0d expected reports never arrived", tracker.outstanding());
      tracker.mismatches += tracker.outstanding();
    end
    $display("summary: %0d cells sent, %0d complete grids, %0d peak reports checked",
             tracker.cells, tracker.grids, tracker.peaks);
    $display("summary: sizes from 1x1 to 1024 columns or rows, clamped sizes, %0d mismatches",
             tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
